### rtl/ssnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssnp_pkg
// Types and constants shared by the size suffix number parser modules.
// ----------------------------------------------------------------------------
package ssnp_pkg;

	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned MUL_CNT_W = $clog2(VALUE_W);
	localparam int unsigned SHIFT_W   = 5;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_LOW_K = 8'h6b;
	localparam logic [7:0] CH_UP_K  = 8'h4b;
	localparam logic [7:0] CH_UP_M  = 8'h4d;
	localparam logic [7:0] CH_UP_G  = 8'h47;

	localparam logic [SHIFT_W-1:0] SH_C = 5'd0;
	localparam logic [SHIFT_W-1:0] SH_W = 5'd1;
	localparam logic [SHIFT_W-1:0] SH_B = 5'd9;
	localparam logic [SHIFT_W-1:0] SH_K = 5'd10;
	localparam logic [SHIFT_W-1:0] SH_M = 5'd20;
	localparam logic [SHIFT_W-1:0] SH_G = 5'd30;

	typedef struct packed {
		logic [7:0] character;
		logic       at_end;
	} char_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid_res;
	} res_item_t;

	typedef enum logic [1:0] {
		PH_DIGIT_DUE,
		PH_IN_DIGITS,
		PH_AFTER_SUFFIX,
		PH_UNUSED
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic mul_step;
		logic finish;
	} ssnp_cmd_t;

	typedef struct packed {
		logic need_mul;
		logic is_end;
		logic mul_done;
		logic out_free;
	} ssnp_status_t;

endpackage

`default_nettype wire

### rtl/ssnp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssnp_ctrl
// Controller: takes items, sequences the shared multiply and the result.
// ----------------------------------------------------------------------------
module ssnp_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  char_valid,
	output logic                 char_stall,
	input  ssnp_pkg::ssnp_status_t status,
	output ssnp_pkg::ssnp_cmd_t  cmd
);
	import ssnp_pkg::*;

	ctl_state_t state_q, state_d;
	logic       end_q, end_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			end_q   <= end_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		end_d        = end_q;
		char_stall   = 1'b1;
		cmd.accept   = 1'b0;
		cmd.mul_step = 1'b0;
		cmd.finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				char_stall = 1'b0;
				cmd.accept = char_valid;
				if (char_valid) begin
					end_d = status.is_end;
					if (status.need_mul) begin
						state_d = ST_MUL;
					end else if (status.is_end) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.mul_done) begin
					state_d = end_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/ssnp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssnp_datapath
// Parse state, digit accumulator, suffix shifter, bit-serial checked
// multiplier and the result register.
// ----------------------------------------------------------------------------
module ssnp_datapath (
	input  wire                    clk,
	input  wire                    arst_n,
	input  ssnp_pkg::char_item_t   char_item,
	input  ssnp_pkg::ssnp_cmd_t    cmd,
	output ssnp_pkg::ssnp_status_t status,
	output logic                   res_valid,
	input  wire                    res_stall,
	output ssnp_pkg::res_item_t    res_item
);
	import ssnp_pkg::*;

	logic [VALUE_W-1:0]   product_q;
	logic [VALUE_W-1:0]   term_q;
	phase_t               phase_q;
	logic                 first_q;
	logic                 err_q;

	logic [VALUE_W-1:0]   mcand_q;
	logic [VALUE_W-1:0]   mplier_q;
	logic [VALUE_W-1:0]   acc_q;
	logic                 ovf_q;
	logic [MUL_CNT_W-1:0] cnt_q;

	logic                 res_valid_q;
	res_item_t            res_q;

	logic [7:0]           ch;
	logic                 is_digit;
	logic                 is_x;
	logic                 is_suffix;
	logic [SHIFT_W-1:0]   sh;
	logic [VALUE_W+3:0]   digit_sum;
	logic                 digit_ovf;
	logic [2*VALUE_W-1:0] shifted;
	logic                 mid_fold;
	logic                 end_fold;
	logic                 fold_ok;
	logic [VALUE_W-1:0]   fold_t;
	logic                 fold_ovf;
	logic [VALUE_W+1:0]   mul_sum;
	logic                 mul_ovf;
	logic                 out_ok;

	assign ch        = char_item.character;
	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_x      = (ch == CH_LOW_X) || (ch == CH_UP_X);
	assign digit_sum = {1'b0, term_q, 3'b000} + {3'b000, term_q, 1'b0}
		+ {{VALUE_W{1'b0}}, ch[3:0]};
	assign digit_ovf = |digit_sum[VALUE_W+3:VALUE_W];

	always_comb begin
		is_suffix = 1'b1;
		unique case (ch)
			CH_C:              sh = SH_C;
			CH_W:              sh = SH_W;
			CH_B:              sh = SH_B;
			CH_LOW_K, CH_UP_K: sh = SH_K;
			CH_UP_M:           sh = SH_M;
			CH_UP_G:           sh = SH_G;
			default: begin
				sh        = SH_C;
				is_suffix = 1'b0;
			end
		endcase
	end

	assign shifted  = {{VALUE_W{1'b0}}, term_q} << sh;
	assign mid_fold = !char_item.at_end && !err_q && (phase_q == PH_IN_DIGITS)
		&& !is_digit && (is_x || is_suffix);
	assign end_fold = char_item.at_end && !err_q && (phase_q == PH_IN_DIGITS);
	assign fold_ovf = mid_fold && !is_x && (|shifted[2*VALUE_W-1:VALUE_W]);
	assign fold_t   = (end_fold || is_x) ? term_q : shifted[VALUE_W-1:0];
	assign fold_ok  = (mid_fold || end_fold) && !fold_ovf;

	// one multiplier bit per step, msb first; overflow is sticky
	assign mul_sum = {1'b0, acc_q, 1'b0}
		+ {2'b00, (mplier_q[VALUE_W-1] ? mcand_q : {VALUE_W{1'b0}})};
	assign mul_ovf = ovf_q || (|mul_sum[VALUE_W+1:VALUE_W]);

	assign out_ok = !err_q && ((phase_q == PH_IN_DIGITS) || (phase_q == PH_AFTER_SUFFIX));

	assign status.need_mul = fold_ok && !first_q;
	assign status.is_end   = char_item.at_end;
	assign status.mul_done = &cnt_q;
	assign status.out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_q   <= '0;
			term_q      <= '0;
			phase_q     <= PH_DIGIT_DUE;
			first_q     <= 1'b1;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
				product_q   <= '0;
				term_q      <= '0;
				phase_q     <= PH_DIGIT_DUE;
				first_q     <= 1'b1;
				err_q       <= 1'b0;
			end else begin
				if (!res_stall) begin
					res_valid_q <= 1'b0;
				end
				if (cmd.mul_step && status.mul_done) begin
					product_q <= mul_sum[VALUE_W-1:0];
					err_q     <= err_q || mul_ovf;
				end
				if (cmd.accept) begin
					if (fold_ok) begin
						term_q <= '0;
						if (first_q) begin
							product_q <= fold_t;
							first_q   <= 1'b0;
						end
					end
					if (!char_item.at_end && !err_q) begin
						unique case (phase_q)
							PH_DIGIT_DUE, PH_IN_DIGITS: begin
								if (is_digit) begin
									if (digit_ovf) begin
										err_q <= 1'b1;
									end else begin
										term_q  <= digit_sum[VALUE_W-1:0];
										phase_q <= PH_IN_DIGITS;
									end
								end else if (phase_q == PH_DIGIT_DUE) begin
									err_q <= 1'b1;
								end else if (is_x) begin
									phase_q <= PH_DIGIT_DUE;
								end else if (is_suffix) begin
									phase_q <= PH_AFTER_SUFFIX;
									if (fold_ovf) begin
										err_q <= 1'b1;
									end
								end else begin
									err_q <= 1'b1;
								end
							end
							PH_AFTER_SUFFIX: begin
								if (is_x) begin
									phase_q <= PH_DIGIT_DUE;
								end else begin
									err_q <= 1'b1;
								end
							end
							PH_UNUSED: begin
								err_q <= 1'b1;
							end
							default: begin
								err_q <= 1'b1;
							end
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && status.need_mul) begin
			mcand_q  <= product_q;
			mplier_q <= fold_t;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			cnt_q    <= '0;
		end else if (cmd.mul_step) begin
			mplier_q <= {mplier_q[VALUE_W-2:0], 1'b0};
			acc_q    <= mul_sum[VALUE_W-1:0];
			ovf_q    <= mul_ovf;
			cnt_q    <= cnt_q + 1'b1;
		end
		if (cmd.finish) begin
			res_q.value     <= out_ok ? product_q : '0;
			res_q.valid_res <= out_ok;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

`default_nettype wire

### rtl/size_suffix_number_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// size_suffix_number_parser
// Parses a decimal operand with size suffixes and x products, one
// character item per handshake, and gives the 64-bit value on the end item.
// ----------------------------------------------------------------------------
// multiply: a character that closes a term after the first one runs a 64-step
//   bit-serial checked multiply of the running product; the input stalls meanwhile
// end item: result registered in the finish state, after a final multiply if
//   one is due; input busy till then, longer while the result register is full
// sharing: one multiplier serves all items, so no new item is taken while it runs
// reset: asynchronous, clears parse state and result valid; ready at once
module size_suffix_number_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  char_valid,
	output logic                 char_stall,
	input  ssnp_pkg::char_item_t char_item,
	output logic                 res_valid,
	input  wire                  res_stall,
	output ssnp_pkg::res_item_t  res_item
);
	import ssnp_pkg::*;

	ssnp_cmd_t    cmd;
	ssnp_status_t status;

	ssnp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.status     (status),
		.cmd        (cmd)
	);

	ssnp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_item (char_item),
		.cmd       (cmd),
		.status    (status),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

### verif/tb_size_suffix_number_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_suffix_number_parser
// Feeds operand strings one character item at a time, each closed by an end
// item, and checks every value and valid flag against a cycle-free parser
// model kept in the testbench. Directed strings hit some error paths and all
// suffixes; random strings are mostly well formed terms with some damage.
// ----------------------------------------------------------------------------
module tb_size_suffix_number_parser;
	import ssnp_pkg::*;

	localparam int ITEM_TARGET  = 1500;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 2000000;

	typedef enum int {
		MG_EMPTY,
		MG_TRAILING_X,
		MG_OVERWRITE,
		MG_INSERT,
		MG_CLEAN
	} mangle_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	char_item_t  char_item = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_item_t   res_item;

	char_item_t  char_queue[$];
	res_item_t   pending_values[$];
	logic [7:0]  suffix_chars[7] = '{CH_C, CH_W, CH_B, CH_LOW_K, CH_UP_K, CH_UP_M, CH_UP_G};

	// parser model state
	logic [63:0] prod_acc;
	logic [63:0] term_acc;
	phase_t      parse_ph;
	logic        no_term_yet;
	logic        parse_err;

	int chars_accepted = 0;
	int drive_idx = 0;
	int pause_idx = 0;
	int error_count = 0;
	int operand_count = 0;
	int valid_count = 0;
	int invalid_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	size_suffix_number_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_item(char_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void clear_parse();
		prod_acc    = '0;
		term_acc    = '0;
		parse_ph    = PH_DIGIT_DUE;
		no_term_yet = 1'b1;
		parse_err   = 1'b0;
	endfunction

	function automatic void close_term(input logic [63:0] factor);
		logic [127:0] scaled;
		logic [127:0] folded;
		scaled = 128'(term_acc) * 128'(factor);
		if (scaled[127:64] != '0) begin
			parse_err = 1'b1;
			return;
		end
		if (no_term_yet) begin
			prod_acc    = scaled[63:0];
			no_term_yet = 1'b0;
		end else begin
			folded = 128'(prod_acc) * 128'(scaled[63:0]);
			if (folded[127:64] != '0)
				parse_err = 1'b1;
			else
				prod_acc = folded[63:0];
		end
		term_acc = '0;
	endfunction

	function automatic logic [63:0] factor_of(input logic [7:0] ch);
		case (ch)
			CH_C:              return 64'd1;
			CH_W:              return 64'd2;
			CH_B:              return 64'd512;
			CH_LOW_K, CH_UP_K: return 64'd1024;
			CH_UP_M:           return 64'd1 << 20;
			CH_UP_G:           return 64'd1 << 30;
			default:           return 64'd0;
		endcase
	endfunction

	function automatic void parse_item(input char_item_t it);
		logic [7:0]   ch;
		logic [7:0]   digit;
		logic         is_digit;
		logic         is_x;
		logic         ok;
		logic [63:0]  factor;
		logic [127:0] grown;
		res_item_t    r;
		ch       = it.character;
		is_digit = ch >= CH_ZERO && ch <= CH_NINE;
		is_x     = ch == CH_LOW_X || ch == CH_UP_X;
		if (it.at_end) begin
			if (!parse_err && parse_ph == PH_IN_DIGITS)
				close_term(64'd1);
			ok = !parse_err && (parse_ph == PH_IN_DIGITS || parse_ph == PH_AFTER_SUFFIX);
			r.value     = ok ? prod_acc : '0;
			r.valid_res = ok;
			pending_values.push_back(r);
			if (ok)
				valid_count++;
			else
				invalid_count++;
			clear_parse();
		end else if (!parse_err) begin
			case (parse_ph)
				PH_DIGIT_DUE, PH_IN_DIGITS: begin
					if (is_digit) begin
						digit = ch - CH_ZERO;
						grown = 128'(term_acc) * 128'd10 + 128'(digit);
						if (grown[127:64] != '0) begin
							parse_err = 1'b1;
						end else begin
							term_acc = grown[63:0];
							parse_ph = PH_IN_DIGITS;
						end
					end else if (parse_ph == PH_DIGIT_DUE) begin
						parse_err = 1'b1;
					end else if (is_x) begin
						close_term(64'd1);
						parse_ph = PH_DIGIT_DUE;
					end else begin
						factor = factor_of(ch);
						if (factor == '0) begin
							parse_err = 1'b1;
						end else begin
							close_term(factor);
							parse_ph = PH_AFTER_SUFFIX;
						end
					end
				end
				PH_AFTER_SUFFIX: begin
					if (is_x)
						parse_ph = PH_DIGIT_DUE;
					else
						parse_err = 1'b1;
				end
				default: parse_err = 1'b1;
			endcase
		end
	endfunction

	function automatic void add_char(input logic [7:0] ch);
		char_item_t it;
		it.character = ch;
		it.at_end    = 1'b0;
		char_queue.push_back(it);
	endfunction

	// the character of an end item is ignored, so it carries noise
	function automatic void add_end();
		char_item_t it;
		it.character = 8'($urandom_range(0, 255));
		it.at_end    = 1'b1;
		char_queue.push_back(it);
		operand_count++;
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
		add_end();
	endfunction

	function automatic void add_random_operand();
		logic [7:0] text[$];
		int         terms;
		int         ndig;
		int         pos;
		mangle_t    kind;
		terms = $urandom_range(1, 3);
		if ($urandom_range(0, 19) == 0)
			terms = $urandom_range(4, 6);
		for (int t = 0; t < terms; t++) begin
			if (t != 0)
				text.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
			ndig = $urandom_range(1, 3);
			if ($urandom_range(0, 14) == 0)
				ndig = $urandom_range(17, 21);
			for (int d = 0; d < ndig; d++)
				text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			if ($urandom_range(0, 1))
				text.push_back(suffix_chars[$urandom_range(0, 6)]);
		end
		kind = ($urandom_range(0, 9) < 4) ? mangle_t'($urandom_range(0, 3)) : MG_CLEAN;
		case (kind)
			MG_EMPTY:      text.delete();
			MG_TRAILING_X: text.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
			MG_OVERWRITE: begin
				pos = $urandom_range(0, text.size() - 1);
				text[pos] = 8'($urandom_range(0, 255));
			end
			MG_INSERT: begin
				pos = $urandom_range(0, text.size());
				text.insert(pos, 8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
		foreach (text[i])
			add_char(text[i]);
		add_end();
	endfunction

	function automatic int send_idle_pct();
		if (chars_accepted < char_queue.size() / 3)
			return 14;
		else if (chars_accepted < 2 * char_queue.size() / 3)
			return 87;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (chars_accepted < char_queue.size() / 3)
			return 87;
		else if (chars_accepted < 2 * char_queue.size() / 3)
			return 14;
		return 0;
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n && !(char_valid && chars_accepted == drive_idx)) begin
			drive_idx = chars_accepted;
			if (drive_idx == pause_idx && pending_values.size() != 0) begin
				char_valid <= 1'b0;
			end else if (drive_idx < char_queue.size() &&
					$urandom_range(0, 99) >= send_idle_pct()) begin
				char_valid <= 1'b1;
				char_item  <= char_queue[drive_idx];
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off late in the run
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (!hold_done && chars_accepted >= 3 * char_queue.size() / 4) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				res_stall <= 1'b1;
			end else begin
				res_stall <= $urandom_range(0, 99) < recv_stall_pct();
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				parse_item(char_item);
				chars_accepted++;
			end
			if (res_valid && !res_stall) begin
				if (pending_values.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result: expected none, got value %h valid %b",
						$time, res_item.value, res_item.valid_res);
				end else begin
					want = pending_values.pop_front();
					if (res_item.value !== want.value) begin
						error_count++;
						$display("%0t: value mismatch: expected %h, got %h",
							$time, want.value, res_item.value);
					end
					if (res_item.valid_res !== want.valid_res) begin
						error_count++;
						$display("%0t: valid flag mismatch: expected %b, got %b",
							$time, want.valid_res, res_item.valid_res);
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		clear_parse();
		// empty, trailing x, zero byte after digits, junk after suffix, top byte
		add_text("");
		add_text("3x");
		add_char(8'h35);
		add_char(8'h00);
		add_end();
		add_text("2k7");
		add_char(8'hff);
		add_end();
		// every suffix and both separators, then a term product overflow
		add_text("2cX3wx5bx1kx1M");
		add_text("1Kx1GX1Gx1G");
		pause_idx = char_queue.size();
		while (char_queue.size() < ITEM_TARGET)
			add_random_operand();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(chars_accepted == char_queue.size() && pending_values.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("parsed %0d operands in %0d character items over %0d cycles",
			operand_count, char_queue.size(), cycle_count);
		$display("results: %0d valid values, %0d rejected operands",
			valid_count, invalid_count);
		if (error_count == 0 && pending_values.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
